[rtl/bfis_pkg.sv]
// Shared types, sizes and codes for the instruction step unit.
package bfis_pkg;

    localparam int PROG_DEPTH = 512;
    localparam int TAPE_DEPTH = 1024;

    localparam int PADDR_W = $clog2(PROG_DEPTH);
    localparam int POS_W   = $clog2(PROG_DEPTH + 1);
    localparam int HEAD_W  = $clog2(TAPE_DEPTH);
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;

    localparam int IN_DATA_W    = 2 * BYTE_W;
    localparam int OUT_FIELDS_W = BYTE_W + STAT_W + POS_W + HEAD_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int STAT_LSB = BYTE_W;
    localparam int POS_LSB  = STAT_LSB + STAT_W;
    localparam int HEAD_LSB = POS_LSB + POS_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD   = 2'd0,
        KIND_STEP   = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK          = 3'd0,
        STAT_FINISHED    = 3'd1,
        STAT_LEFT_END    = 3'd2,
        STAT_UNMATCHED_C = 3'd3,
        STAT_UNMATCHED_O = 3'd4,
        STAT_TAPE_FULL   = 3'd5,
        STAT_PROG_FULL   = 3'd6
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCAN_BACK,
        ST_SCAN_FWD
    } state_t;

    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_LT    = 8'h3C;
    localparam logic [BYTE_W-1:0] CH_GT    = 8'h3E;
    localparam logic [BYTE_W-1:0] CH_OPEN  = 8'h5B;
    localparam logic [BYTE_W-1:0] CH_CLOSE = 8'h5D;

endpackage

[rtl/bfis_ram.sv]
// Simple dual-port RAM, one write port, one registered read port.
module bfis_ram #(
    parameter int DEPTH = 512,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/brainfuck_instruction_step_unit.sv]
// Top level: tape machine that loads, clears and steps one instruction per word.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | [7:0] program_byte, [15:8] input_byte  | [1:0] kind
//  m_      | out | [7:0] out_byte, [10:8] status,          | out_valid
//          |     | [20:11] position, [30:21] head          |
//
// Load, clear, unused, halted and finished words answer in the cycle after they are
// taken. Plain step: program and tape RAM read, then execute. Bracket jump: one
// program RAM read per scanned byte. After reset the tape RAM is swept to zero over
// all TAPE_DEPTH (1024) entries with s_tready low. A word is only taken when the
// output register is free or being drained; m_tready low stalls the result.
module brainfuck_instruction_step_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bfis_pkg::IN_DATA_W-1:0]    s_tdata,   // program_byte, input_byte
    input  logic [bfis_pkg::KIND_W-1:0]       s_tuser,   // kind
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bfis_pkg::OUT_DATA_W-1:0]   m_tdata,   // out_byte, status, position, head
    output logic                              m_tuser    // out_valid
);

    localparam int PADDR_W = bfis_pkg::PADDR_W;
    localparam int POS_W   = bfis_pkg::POS_W;
    localparam int HEAD_W  = bfis_pkg::HEAD_W;
    localparam int BYTE_W  = bfis_pkg::BYTE_W;

    bfis_pkg::state_t  state_reg, state_next;
    bfis_pkg::status_t halt_reg, halt_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  len_reg, len_next;
    logic [HEAD_W-1:0] head_reg, head_next;
    logic [HEAD_W-1:0] clr_reg, clr_next;
    logic [POS_W-1:0]  k_reg, k_next;
    logic [POS_W-1:0]  depth_reg, depth_next;
    logic              m_tvalid_reg, m_tvalid_next;
    logic              m_user_reg, m_user_next;
    logic [bfis_pkg::OUT_FIELDS_W-1:0] m_data_reg, m_data_next;

    logic              out_free;
    logic              accept;
    logic              post;
    logic              res_emit;
    logic [BYTE_W-1:0] res_byte;
    bfis_pkg::status_t res_status;
    bfis_pkg::kind_t   kind;
    logic [BYTE_W-1:0] in_pbyte;
    logic [BYTE_W-1:0] in_ibyte;
    logic [BYTE_W-1:0] in_ibyte_reg;

    logic               prog_we;
    logic [PADDR_W-1:0] prog_waddr;
    logic [PADDR_W-1:0] prog_raddr;
    logic [BYTE_W-1:0]  prog_rdata;
    logic               tape_we;
    logic [HEAD_W-1:0]  tape_waddr;
    logic [BYTE_W-1:0]  tape_wdata;
    logic [BYTE_W-1:0]  tape_rdata;

    assign kind     = bfis_pkg::kind_t'(s_tuser);
    assign in_pbyte = s_tdata[BYTE_W-1:0];
    assign in_ibyte = s_tdata[2*BYTE_W-1:BYTE_W];
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == bfis_pkg::ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    bfis_ram #(.DEPTH(bfis_pkg::PROG_DEPTH), .WIDTH(BYTE_W)) u_prog_ram (
        .aclk  (aclk),
        .we    (prog_we),
        .waddr (prog_waddr),
        .wdata (in_pbyte),
        .raddr (prog_raddr),
        .rdata (prog_rdata)
    );

    bfis_ram #(.DEPTH(bfis_pkg::TAPE_DEPTH), .WIDTH(BYTE_W)) u_tape_ram (
        .aclk  (aclk),
        .we    (tape_we),
        .waddr (tape_waddr),
        .wdata (tape_wdata),
        .raddr (head_reg),
        .rdata (tape_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= bfis_pkg::ST_CLEAR;
            halt_reg     <= bfis_pkg::STAT_OK;
            pos_reg      <= '0;
            len_reg      <= '0;
            head_reg     <= '0;
            clr_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            halt_reg     <= halt_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            head_reg     <= head_next;
            clr_reg      <= clr_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg      <= k_next;
        depth_reg  <= depth_next;
        m_user_reg <= m_user_next;
        m_data_reg <= m_data_next;
    end

    always_comb begin
        state_next = state_reg;
        halt_next  = halt_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        head_next  = head_reg;
        clr_next   = clr_reg;
        k_next     = k_reg;
        depth_next = depth_reg;
        post       = 1'b0;
        res_emit   = 1'b0;
        res_byte   = '0;
        res_status = bfis_pkg::STAT_OK;
        prog_we    = 1'b0;
        prog_waddr = len_reg[PADDR_W-1:0];
        prog_raddr = pos_reg[PADDR_W-1:0];
        tape_we    = 1'b0;
        tape_waddr = head_reg;
        tape_wdata = '0;

        case (state_reg)
            bfis_pkg::ST_CLEAR: begin
                tape_we    = 1'b1;
                tape_waddr = clr_reg;
                clr_next   = clr_reg + HEAD_W'(1);
                if (clr_reg == HEAD_W'(bfis_pkg::TAPE_DEPTH - 1)) begin
                    state_next = bfis_pkg::ST_IDLE;
                end
            end

            bfis_pkg::ST_IDLE: begin
                if (accept) begin
                    post = 1'b1;
                    if (kind == bfis_pkg::KIND_CLEAR) begin
                        len_next  = '0;
                        pos_next  = '0;
                        halt_next = bfis_pkg::STAT_OK;
                    end else if (kind == bfis_pkg::KIND_UNUSED
                                 || halt_reg != bfis_pkg::STAT_OK) begin
                        res_status = halt_reg;
                    end else if (kind == bfis_pkg::KIND_LOAD) begin
                        if (len_reg >= POS_W'(bfis_pkg::PROG_DEPTH)) begin
                            halt_next  = bfis_pkg::STAT_PROG_FULL;
                            res_status = bfis_pkg::STAT_PROG_FULL;
                        end else begin
                            prog_we  = 1'b1;
                            len_next = len_reg + POS_W'(1);
                        end
                    end else if (pos_reg >= len_reg) begin
                        res_status = bfis_pkg::STAT_FINISHED;
                    end else begin
                        post       = 1'b0;
                        state_next = bfis_pkg::ST_EXEC;
                    end
                end
            end

            bfis_pkg::ST_EXEC: begin
                if (out_free) begin
                    post     = 1'b1;
                    pos_next = pos_reg + POS_W'(1);
                    case (prog_rdata)
                        bfis_pkg::CH_DOT: begin
                            res_emit = 1'b1;
                            res_byte = tape_rdata;
                        end
                        bfis_pkg::CH_PLUS: begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_rdata + BYTE_W'(1);
                        end
                        bfis_pkg::CH_MINUS: begin
                            tape_we    = 1'b1;
                            tape_wdata = tape_rdata - BYTE_W'(1);
                        end
                        bfis_pkg::CH_COMMA: begin
                            tape_we    = 1'b1;
                            tape_wdata = in_ibyte_reg;
                        end
                        bfis_pkg::CH_LT: begin
                            if (head_reg == '0) begin
                                pos_next   = pos_reg;
                                res_status = bfis_pkg::STAT_LEFT_END;
                            end else begin
                                head_next = head_reg - HEAD_W'(1);
                            end
                        end
                        bfis_pkg::CH_GT: begin
                            if (head_reg == HEAD_W'(bfis_pkg::TAPE_DEPTH - 1)) begin
                                pos_next   = pos_reg;
                                res_status = bfis_pkg::STAT_TAPE_FULL;
                            end else begin
                                head_next = head_reg + HEAD_W'(1);
                            end
                        end
                        bfis_pkg::CH_CLOSE: begin
                            if (tape_rdata != '0) begin
                                pos_next = pos_reg;
                                if (pos_reg == '0) begin
                                    res_status = bfis_pkg::STAT_UNMATCHED_C;
                                end else begin
                                    post       = 1'b0;
                                    k_next     = pos_reg - POS_W'(1);
                                    depth_next = POS_W'(1);
                                    prog_raddr = k_next[PADDR_W-1:0];
                                    state_next = bfis_pkg::ST_SCAN_BACK;
                                end
                            end
                        end
                        bfis_pkg::CH_OPEN: begin
                            if (tape_rdata == '0) begin
                                pos_next = pos_reg;
                                k_next   = pos_reg + POS_W'(1);
                                if (k_next >= len_reg) begin
                                    res_status = bfis_pkg::STAT_UNMATCHED_O;
                                end else begin
                                    post       = 1'b0;
                                    depth_next = POS_W'(1);
                                    prog_raddr = k_next[PADDR_W-1:0];
                                    state_next = bfis_pkg::ST_SCAN_FWD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (post) begin
                        state_next = bfis_pkg::ST_IDLE;
                    end
                    if (post && res_status != bfis_pkg::STAT_OK) begin
                        halt_next = res_status;
                    end
                end
            end

            bfis_pkg::ST_SCAN_BACK: begin
                prog_raddr = k_reg[PADDR_W-1:0];
                if (out_free) begin
                    if (prog_rdata == bfis_pkg::CH_OPEN && depth_reg == POS_W'(1)) begin
                        post       = 1'b1;
                        pos_next   = k_reg;
                        state_next = bfis_pkg::ST_IDLE;
                    end else if (k_reg == '0) begin
                        post       = 1'b1;
                        res_status = bfis_pkg::STAT_UNMATCHED_C;
                        halt_next  = bfis_pkg::STAT_UNMATCHED_C;
                        state_next = bfis_pkg::ST_IDLE;
                    end else begin
                        if (prog_rdata == bfis_pkg::CH_CLOSE) begin
                            depth_next = depth_reg + POS_W'(1);
                        end else if (prog_rdata == bfis_pkg::CH_OPEN) begin
                            depth_next = depth_reg - POS_W'(1);
                        end
                        k_next     = k_reg - POS_W'(1);
                        prog_raddr = k_next[PADDR_W-1:0];
                    end
                end
            end

            bfis_pkg::ST_SCAN_FWD: begin
                prog_raddr = k_reg[PADDR_W-1:0];
                if (out_free) begin
                    if (prog_rdata == bfis_pkg::CH_CLOSE && depth_reg == POS_W'(1)) begin
                        post       = 1'b1;
                        pos_next   = k_reg + POS_W'(1);
                        state_next = bfis_pkg::ST_IDLE;
                    end else if (k_reg + POS_W'(1) >= len_reg) begin
                        post       = 1'b1;
                        res_status = bfis_pkg::STAT_UNMATCHED_O;
                        halt_next  = bfis_pkg::STAT_UNMATCHED_O;
                        state_next = bfis_pkg::ST_IDLE;
                    end else begin
                        if (prog_rdata == bfis_pkg::CH_OPEN) begin
                            depth_next = depth_reg + POS_W'(1);
                        end else if (prog_rdata == bfis_pkg::CH_CLOSE) begin
                            depth_next = depth_reg - POS_W'(1);
                        end
                        k_next     = k_reg + POS_W'(1);
                        prog_raddr = k_next[PADDR_W-1:0];
                    end
                end
            end

            default: begin
                state_next = bfis_pkg::ST_IDLE;
            end
        endcase
    end

    // input byte for ',' is held from the accepted word
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_ibyte_reg <= in_ibyte;
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_user_next   = m_user_reg;
        m_data_next   = m_data_reg;
        if (post) begin
            m_tvalid_next = 1'b1;
            m_user_next   = res_emit;
            m_data_next   = {head_next, pos_next, res_status, res_byte};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_user_reg;
    assign m_tdata  = {(bfis_pkg::OUT_DATA_W - bfis_pkg::OUT_FIELDS_W)'(0), m_data_reg};

endmodule

[rtl/bfis_sva.sv]
// Port-level checks for the instruction step unit, bound to the top level.
module bfis_sva (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [bfis_pkg::IN_DATA_W-1:0]    s_tdata,
    input logic [bfis_pkg::KIND_W-1:0]       s_tuser,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bfis_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                              m_tuser
);

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // tape sweep holds off input right after reset
    a_sweep_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input taken during tape sweep");

    // a word is only taken when the result slot can drain
    a_ready_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (!m_tvalid || m_tready))
        else $error("input ready while result stalled");

    // non-step words answer on the next cycle
    a_fast_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser != bfis_pkg::KIND_STEP |=> m_tvalid)
        else $error("missing one-cycle result");

    // clear reports ok at program position zero
    a_clear_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s_tuser == bfis_pkg::KIND_CLEAR |=>
        m_tdata[bfis_pkg::POS_LSB-1:bfis_pkg::STAT_LSB] == bfis_pkg::STAT_OK
        && m_tdata[bfis_pkg::HEAD_LSB-1:bfis_pkg::POS_LSB] == '0)
        else $error("bad clear result");

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

endmodule

bind brainfuck_instruction_step_unit bfis_sva u_bfis_sva (.*);

[tb/tb_brainfuck_instruction_step_unit.sv]
// Testbench for the tape machine step unit: streams words and checks every result word.
module tb_brainfuck_instruction_step_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int KIND_W     = bfis_pkg::KIND_W;
    localparam int BYTE_W     = bfis_pkg::BYTE_W;
    localparam int STAT_W     = bfis_pkg::STAT_W;
    localparam int POS_W      = bfis_pkg::POS_W;
    localparam int HEAD_W     = bfis_pkg::HEAD_W;
    localparam int IN_DATA_W  = bfis_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = bfis_pkg::OUT_DATA_W;
    localparam int STAT_LSB   = bfis_pkg::STAT_LSB;
    localparam int POS_LSB    = bfis_pkg::POS_LSB;
    localparam int HEAD_LSB   = bfis_pkg::HEAD_LSB;
    localparam int PROG_DEPTH = bfis_pkg::PROG_DEPTH;
    localparam int TAPE_DEPTH = bfis_pkg::TAPE_DEPTH;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 600;
    localparam int HOLD_CYCLES  = 400;
    localparam int WALK_BODY    = 60;
    localparam int NUM_PROGRAMS = 6;

    typedef struct packed {
        logic                out_valid;
        logic [BYTE_W-1:0]   out_byte;
        bfis_pkg::status_t   status;
        logic [POS_W-1:0]    position;
        logic [HEAD_W-1:0]   head;
    } step_result_t;

    typedef struct packed {
        logic [KIND_W-1:0]   kind;
        logic [BYTE_W-1:0]   prog_byte;
        logic [BYTE_W-1:0]   in_byte;
        logic                typed;
        step_result_t        res;
    } table_row_t;

    localparam step_result_t UNTYPED = '{1'b0, 8'h00, bfis_pkg::STAT_OK, 10'd0, 10'd0};

    localparam table_row_t DIRECTED_WORDS [27] = '{
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_FINISHED, 10'd0, 10'd0}},
        '{bfis_pkg::KIND_UNUSED, 8'hFF, 8'hFF, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_OK, 10'd0, 10'd0}},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_LT, 8'hFF, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_OK, 10'd0, 10'd0}},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_LEFT_END, 10'd0, 10'd0}},
        '{bfis_pkg::KIND_LOAD, 8'hFF, 8'h00, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_LEFT_END, 10'd0, 10'd0}},
        '{bfis_pkg::KIND_CLEAR, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_OK, 10'd0, 10'd0}},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_COMMA, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_PLUS,  8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_DOT,   8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_OPEN,  8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_MINUS, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_CLOSE, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_PLUS,  8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_CLOSE, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'hFF, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b1,
          '{1'b1, 8'h00, bfis_pkg::STAT_OK, 10'd3, 10'd0}},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_UNMATCHED_C, 10'd7, 10'd0}},
        '{bfis_pkg::KIND_CLEAR, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_OK, 10'd0, 10'd0}},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_GT,   8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, 8'h00,             8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_LOAD, bfis_pkg::CH_OPEN, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b0, UNTYPED},
        '{bfis_pkg::KIND_STEP, 8'h00, 8'h00, 1'b1,
          '{1'b0, 8'h00, bfis_pkg::STAT_UNMATCHED_O, 10'd2, 10'd1}}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;   // program_byte, input_byte
    logic [KIND_W-1:0]     s_tuser;   // kind
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;   // out_byte, status, position, head
    logic                  m_tuser;   // out_valid

    // machine state mirror
    logic [BYTE_W-1:0] prog_mem [PROG_DEPTH];
    logic [BYTE_W-1:0] tape [TAPE_DEPTH];
    int                prog_len;
    int                prog_pos;
    int                head_pos;
    bfis_pkg::status_t halt;

    step_result_t      reports_due [$];
    int                mismatch_count = 0;
    int                idle_cycles = 0;
    int                burst_left = 0;
    bit                hold_req = 1'b0;

    brainfuck_instruction_step_unit i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    function automatic step_result_t machine_step(input logic [KIND_W-1:0] kind,
                                                  input logic [BYTE_W-1:0] pb,
                                                  input logic [BYTE_W-1:0] ib);
        step_result_t      r;
        bfis_pkg::status_t st;
        logic [BYTE_W-1:0] cur_val;
        int                depth;
        int                k;
        int                target;
        bit                jumped;
        r = UNTYPED;
        st = bfis_pkg::STAT_OK;
        jumped = 1'b0;
        target = 0;
        if (kind == bfis_pkg::KIND_CLEAR) begin
            prog_len = 0;
            prog_pos = 0;
            halt = bfis_pkg::STAT_OK;
        end else if (kind == bfis_pkg::KIND_UNUSED || halt != bfis_pkg::STAT_OK) begin
            st = halt;
        end else if (kind == bfis_pkg::KIND_LOAD) begin
            if (prog_len >= PROG_DEPTH) begin
                halt = bfis_pkg::STAT_PROG_FULL;
                st = bfis_pkg::STAT_PROG_FULL;
            end else begin
                prog_mem[prog_len] = pb;
                prog_len++;
            end
        end else if (prog_pos >= prog_len) begin
            st = bfis_pkg::STAT_FINISHED;
        end else begin
            cur_val = tape[head_pos];
            case (prog_mem[prog_pos])
                bfis_pkg::CH_DOT: begin
                    r.out_valid = 1'b1;
                    r.out_byte = cur_val;
                end
                bfis_pkg::CH_PLUS:  tape[head_pos] = cur_val + 8'd1;
                bfis_pkg::CH_MINUS: tape[head_pos] = cur_val - 8'd1;
                bfis_pkg::CH_COMMA: tape[head_pos] = ib;
                bfis_pkg::CH_LT: begin
                    if (head_pos == 0) st = bfis_pkg::STAT_LEFT_END;
                    else head_pos--;
                end
                bfis_pkg::CH_GT: begin
                    if (head_pos == TAPE_DEPTH - 1) st = bfis_pkg::STAT_TAPE_FULL;
                    else head_pos++;
                end
                bfis_pkg::CH_CLOSE: begin
                    if (cur_val != 0) begin
                        depth = 1;
                        k = prog_pos;
                        while (depth != 0 && st == bfis_pkg::STAT_OK) begin
                            if (k == 0) begin
                                st = bfis_pkg::STAT_UNMATCHED_C;
                            end else begin
                                k--;
                                if (prog_mem[k] == bfis_pkg::CH_CLOSE) depth++;
                                else if (prog_mem[k] == bfis_pkg::CH_OPEN) depth--;
                            end
                        end
                        jumped = 1'b1;
                        target = k;
                    end
                end
                bfis_pkg::CH_OPEN: begin
                    if (cur_val == 0) begin
                        depth = 1;
                        k = prog_pos;
                        while (depth != 0 && st == bfis_pkg::STAT_OK) begin
                            k++;
                            if (k >= prog_len) st = bfis_pkg::STAT_UNMATCHED_O;
                            else if (prog_mem[k] == bfis_pkg::CH_OPEN) depth++;
                            else if (prog_mem[k] == bfis_pkg::CH_CLOSE) depth--;
                        end
                        jumped = 1'b1;
                        target = k + 1;
                    end
                end
                default: ;
            endcase
            // errors latch and leave the position on the failing instruction
            if (st != bfis_pkg::STAT_OK) halt = st;
            else if (jumped) prog_pos = target;
            else prog_pos++;
        end
        r.status = st;
        r.position = prog_pos[POS_W-1:0];
        r.head = head_pos[HEAD_W-1:0];
        return r;
    endfunction

    task automatic offer_word(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] pb,
                              input logic [BYTE_W-1:0] ib, input logic typed,
                              input step_result_t typed_res);
        step_result_t predicted;
        int           gap;
        predicted = machine_step(kind, pb, ib);
        reports_due.push_back(typed ? typed_res : predicted);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                s_tdata = IN_DATA_W'($urandom);
                s_tuser = KIND_W'($urandom);
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata = {ib, pb};
        s_tuser = kind;
        do @(posedge aclk); while (!s_tready);
    endtask

    // receiver: random stall modes, plus one long hold-off on request
    initial begin
        int          mode;
        int          left;
        logic [31:0] mask;
        m_tready = 1'b0;
        mode = 0;
        left = 0;
        mask = '0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                if (left == 0) begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(16, 128);
                    mask = $urandom;
                end
                left--;
                case (mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    2: m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = mask[left % 32];
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        step_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reports_due.size() == 0) begin
                $error("result word with nothing outstanding");
                mismatch_count++;
            end else begin
                want = reports_due.pop_front();
                if (m_tuser !== want.out_valid) begin
                    $error("out_valid: expected %0d, got %0d", want.out_valid, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[BYTE_W-1:0] !== want.out_byte) begin
                    $error("out_byte: expected %0d, got %0d", want.out_byte,
                           m_tdata[BYTE_W-1:0]);
                    mismatch_count++;
                end
                if (m_tdata[STAT_LSB +: STAT_W] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status,
                           m_tdata[STAT_LSB +: STAT_W]);
                    mismatch_count++;
                end
                if (m_tdata[POS_LSB +: POS_W] !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position,
                           m_tdata[POS_LSB +: POS_W]);
                    mismatch_count++;
                end
                if (m_tdata[HEAD_LSB +: HEAD_W] !== want.head) begin
                    $error("head: expected %0d, got %0d", want.head,
                           m_tdata[HEAD_LSB +: HEAD_W]);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int                steps;
        int                nest;
        int                plen;
        int                r;
        logic [BYTE_W-1:0] op_byte;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        prog_len = 0;
        prog_pos = 0;
        head_pos = 0;
        halt = bfis_pkg::STAT_OK;
        foreach (tape[i]) tape[i] = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < $size(DIRECTED_WORDS); i++) begin
            offer_word(DIRECTED_WORDS[i].kind, DIRECTED_WORDS[i].prog_byte,
                       DIRECTED_WORDS[i].in_byte, DIRECTED_WORDS[i].typed,
                       DIRECTED_WORDS[i].res);
        end

        // full-length loop program; the receiver holds off while it streams in
        hold_req = 1'b1;
        offer_word(bfis_pkg::KIND_CLEAR, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
        offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_COMMA, 8'($urandom), 1'b0, UNTYPED);
        offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_OPEN, 8'($urandom), 1'b0, UNTYPED);
        repeat (PROG_DEPTH - 4) begin
            op_byte = ($urandom_range(0, 15) == 0) ? {1'b1, 7'($urandom)} : bfis_pkg::CH_GT;
            offer_word(bfis_pkg::KIND_LOAD, op_byte, 8'($urandom), 1'b0, UNTYPED);
        end
        offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_COMMA, 8'($urandom), 1'b0, UNTYPED);
        offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_CLOSE, 8'($urandom), 1'b0, UNTYPED);
        while (halt == bfis_pkg::STAT_OK && prog_pos < prog_len) begin
            offer_word(bfis_pkg::KIND_STEP, 8'($urandom),
                       (head_pos > 300) ? 8'h00 : 8'($urandom_range(1, 255)), 1'b0, UNTYPED);
        end
        repeat (3) offer_word(bfis_pkg::KIND_LOAD, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
        offer_word(bfis_pkg::KIND_STEP, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
        offer_word(bfis_pkg::KIND_CLEAR, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);

        // short loop walking right until the tape end
        offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_COMMA, 8'($urandom), 1'b0, UNTYPED);
        offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_OPEN, 8'($urandom), 1'b0, UNTYPED);
        repeat (WALK_BODY) begin
            op_byte = ($urandom_range(0, 15) == 0) ? {1'b1, 7'($urandom)} : bfis_pkg::CH_GT;
            offer_word(bfis_pkg::KIND_LOAD, op_byte, 8'($urandom), 1'b0, UNTYPED);
        end
        offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_COMMA, 8'($urandom), 1'b0, UNTYPED);
        offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_CLOSE, 8'($urandom), 1'b0, UNTYPED);
        steps = 0;
        while (halt == bfis_pkg::STAT_OK && prog_pos < prog_len && steps < 3000) begin
            offer_word(bfis_pkg::KIND_STEP, 8'($urandom), 8'($urandom_range(1, 255)),
                       1'b0, UNTYPED);
            steps++;
        end
        repeat (2) offer_word(bfis_pkg::KIND_STEP, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
        offer_word(bfis_pkg::KIND_UNUSED, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);

        // random short programs, mostly with balanced brackets
        repeat (NUM_PROGRAMS) begin
            if ($urandom_range(0, 4) != 0) begin
                offer_word(bfis_pkg::KIND_CLEAR, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
            end
            plen = $urandom_range(4, 20);
            nest = 0;
            for (int j = 0; j < plen; j++) begin
                r = $urandom_range(0, 15);
                if (r == 0) begin
                    op_byte = 8'($urandom);
                end else if (r < 3 && nest < 3) begin
                    op_byte = bfis_pkg::CH_OPEN;
                    nest++;
                end else if (r < 5 && nest > 0) begin
                    op_byte = bfis_pkg::CH_CLOSE;
                    nest--;
                end else if (r == 5) begin
                    op_byte = $urandom_range(0, 1) ? bfis_pkg::CH_OPEN : bfis_pkg::CH_CLOSE;
                end else begin
                    case ($urandom_range(0, 7))
                        0: op_byte = bfis_pkg::CH_PLUS;
                        1: op_byte = bfis_pkg::CH_MINUS;
                        2: op_byte = bfis_pkg::CH_DOT;
                        3: op_byte = bfis_pkg::CH_COMMA;
                        4: op_byte = bfis_pkg::CH_GT;
                        default: op_byte = bfis_pkg::CH_LT;
                    endcase
                end
                offer_word(bfis_pkg::KIND_LOAD, op_byte, 8'($urandom), 1'b0, UNTYPED);
            end
            while (nest > 0) begin
                offer_word(bfis_pkg::KIND_LOAD, bfis_pkg::CH_CLOSE, 8'($urandom), 1'b0, UNTYPED);
                nest--;
            end
            steps = 0;
            while (halt == bfis_pkg::STAT_OK && prog_pos < prog_len && steps < 40) begin
                r = $urandom_range(0, 19);
                if (r == 0) begin
                    offer_word(bfis_pkg::KIND_UNUSED, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
                end else if (r == 1) begin
                    offer_word(bfis_pkg::KIND_LOAD, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
                end else begin
                    offer_word(bfis_pkg::KIND_STEP, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
                end
                steps++;
            end
            offer_word(bfis_pkg::KIND_STEP, 8'($urandom), 8'($urandom), 1'b0, UNTYPED);
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (reports_due.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/bfis_pkg.sv
rtl/bfis_ram.sv
rtl/brainfuck_instruction_step_unit.sv
rtl/bfis_sva.sv
tb/tb_brainfuck_instruction_step_unit.sv
